// ===== sv/sltsu_pkg.sv =====
// Shared types, constants and helper functions of the SSTV line tone scheduler.
// No dependencies; imported by every module of the block.
package sltsu_pkg;

    localparam int MAX_LINE_WIDTH = 512;
    localparam int MAX_LINES      = 1024;

    localparam int IDX_W    = $clog2(MAX_LINE_WIDTH);
    localparam int CNT_W    = $clog2(MAX_LINE_WIDTH + 1);
    localparam int SAMPLE_W = 16;
    localparam int TONE_W   = 12;
    localparam int PIX_W    = 8;
    localparam int LW_W     = 10;
    localparam int NL_W     = 11;
    localparam int LCNT_W   = 10;
    localparam int PROD_W   = CNT_W + SAMPLE_W;
    localparam int NUM_W    = PROD_W + 1;
    localparam int STEP_W   = $clog2(NUM_W + 1);
    localparam int CFG_IDX_W = 3;

    typedef logic [CNT_W-1:0] t_cnt;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_LINES   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_PORCH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATION  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PORCH       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LUMA        = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CHROMA      = 3'd7;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    localparam logic [TONE_W-1:0] TONE_SYNC    = 12'd1200;
    localparam logic [TONE_W-1:0] TONE_BLACK   = 12'd1500;
    localparam logic [TONE_W-1:0] TONE_SEP_ODD = 12'd2300;
    localparam logic [TONE_W-1:0] TONE_PORCH   = 12'd1900;

    // The 3.1372549 step sits just below 160/51, so floor(v*step) equals
    // floor((160v-1)/51) for v > 0. The /51 is a reciprocal multiply, exact
    // for every numerator below 2^24/50.
    localparam int TONE_SCALE = 160;
    localparam int TONE_RECIP = 328966;
    localparam int TONE_SHIFT = 24;
    localparam int TONE_X_W   = 16;
    localparam int TONE_P_W   = 35;
    localparam int TONE_OFF_W = 10;

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_SYNC,
        PH_SPORCH,
        PH_LUMA,
        PH_SEP,
        PH_PORCH,
        PH_CHROMA
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_EMIT
    } t_state;

    function automatic t_cnt eff_width(input logic [LW_W-1:0] lw);
        if (lw == '0) begin
            return t_cnt'(1);
        end
        if (int'(lw) > MAX_LINE_WIDTH) begin
            return t_cnt'(MAX_LINE_WIDTH);
        end
        return t_cnt'(lw);
    endfunction

    function automatic logic [NL_W-1:0] eff_lines(input logic [NL_W-1:0] nl);
        if (nl == '0) begin
            return NL_W'(1);
        end
        if (int'(nl) > MAX_LINES) begin
            return NL_W'(MAX_LINES);
        end
        return nl;
    endfunction

    function automatic logic [TONE_OFF_W-1:0] tone_offset(input logic [PIX_W-1:0] v);
        logic [TONE_X_W-1:0] x;
        logic [TONE_P_W-1:0] p;
        x = TONE_X_W'(v) * TONE_X_W'(TONE_SCALE) - TONE_X_W'(1);
        p = TONE_P_W'(x) * TONE_P_W'(TONE_RECIP);
        if (v == '0) begin
            return '0;
        end
        return TONE_OFF_W'(p >> TONE_SHIFT);
    endfunction

endpackage

// ===== sv/sltsu_line_ram.sv =====
// Scan-line pixel store: luma and chroma memories, one write and one read port.
// Read data is registered. Depends on sltsu_pkg.
module sltsu_line_ram
    import sltsu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  logic [PIX_W-1:0] i_wr_luma,
    input  logic [PIX_W-1:0] i_wr_chroma,
    input  logic [IDX_W-1:0] i_rd_addr,
    output logic [PIX_W-1:0] o_rd_luma,
    output logic [PIX_W-1:0] o_rd_chroma
);

    logic [PIX_W-1:0] r_luma_mem   [MAX_LINE_WIDTH];
    logic [PIX_W-1:0] r_chroma_mem [MAX_LINE_WIDTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_luma_mem[i_wr_addr]   <= i_wr_luma;
            r_chroma_mem[i_wr_addr] <= i_wr_chroma;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_luma   <= r_luma_mem[i_rd_addr];
        o_rd_chroma <= r_chroma_mem[i_rd_addr];
    end

endmodule

// ===== sv/sltsu_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Used for the ceiling splits of the pixel scan lengths. Depends on sltsu_pkg.
module sltsu_div
    import sltsu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_dividend,
    input  t_cnt             i_divisor,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quotient
);

    logic              r_busy, n_busy;
    logic [STEP_W-1:0] r_step, n_step;
    t_cnt              r_rem, n_rem;
    t_cnt              r_div, n_div;
    logic [NUM_W-1:0]  r_quo, n_quo;

    logic [CNT_W:0] trial;
    logic [CNT_W:0] diff;
    logic           fits;

    always_comb begin
        trial  = {r_rem, r_quo[NUM_W-1]};
        diff   = trial - {1'b0, r_div};
        fits   = (trial >= {1'b0, r_div});
        n_busy = r_busy;
        n_step = r_step;
        n_rem  = r_rem;
        n_div  = r_div;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = STEP_W'(NUM_W);
            n_rem  = '0;
            n_div  = i_divisor;
            n_quo  = i_dividend;
        end else if (r_busy) begin
            // dividend shifts out at the top while quotient bits shift in
            n_rem  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            n_quo  = {r_quo[NUM_W-2:0], fits};
            n_step = r_step - STEP_W'(1);
            if (r_step == STEP_W'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
        r_rem <= n_rem;
        r_div <= n_div;
        r_quo <= n_quo;
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

// ===== sv/sstv_line_tone_scheduler_unit.sv =====
// Top level of the SSTV line tone scheduler: config registers, segment sequencer,
// pixel tone and length datapath. Depends on sltsu_pkg, sltsu_line_ram, sltsu_div.
//
// Usage: the input channel (i_valid/o_ready) carries one command per transaction.
// i_cmd = load writes one pixel (Y plus Cb or Cr by line parity) into the line
// store; the load that fills the last pixel of the line arms emission. i_cmd =
// request returns the next tone segment on the output channel (o_valid/i_ready):
// sync, sync porch, one luma segment per pixel, separation, porch, one chroma
// segment per pixel. A request while the line is still loading, and a load while
// the line is emitting, produce nothing.
// A new command is taken only in the idle state, so each one is through the
// sequencer before the next is accepted. A load is written to the line store when
// accepted; a fixed segment passes through the emit state; a pixel segment passes
// through the read, divide and emit states, its sample count split by two bit-serial
// ceiling dividers, one quotient bit per cycle. The output register holds a finished
// result until taken; while it is full a new request completes its work and then waits for the slot.
// The config channel (i_cfg_valid/o_cfg_ready) is always ready and writes one
// register per transaction; write it only while no work is outstanding.
// Reset (synchronous, active low) restores register defaults and the line and
// segment counters. The line store is not cleared and needs no clearing pass.
module sstv_line_tone_scheduler_unit
    import sltsu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_cmd,
    input  logic [PIX_W-1:0]     i_luma,
    input  logic [PIX_W-1:0]     i_blue_diff,
    input  logic [PIX_W-1:0]     i_red_diff,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [TONE_W-1:0]    o_tone_hz,
    output logic [SAMPLE_W-1:0]  o_sample_count,
    output logic                 o_line_done,
    output logic                 o_frame_done,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SAMPLE_W-1:0]  i_cfg_data
);

    // configuration
    logic [LW_W-1:0]     r_line_width;
    logic [NL_W-1:0]     r_num_lines;
    logic [SAMPLE_W-1:0] r_sync, r_sync_porch, r_separation, r_porch;
    logic [SAMPLE_W-1:0] r_luma_samples, r_chroma_samples;

    // sequencer state
    t_state              r_state, n_state;
    t_phase              r_phase, n_phase;
    logic [LCNT_W-1:0]   r_line_cnt, n_line_cnt;
    t_cnt                r_load_idx, n_load_idx;
    t_cnt                r_emit_idx, n_emit_idx;
    logic                r_sel_chroma, n_sel_chroma;
    logic [TONE_OFF_W-1:0] r_tone_off, n_tone_off;

    // pending result
    logic [TONE_W-1:0]   r_res_tone, n_res_tone;
    logic [SAMPLE_W-1:0] r_res_count, n_res_count;
    logic                r_res_ldone, n_res_ldone;
    logic                r_res_fdone, n_res_fdone;

    // output register
    logic                r_o_valid, n_o_valid;
    logic [TONE_W-1:0]   r_o_tone, n_o_tone;
    logic [SAMPLE_W-1:0] r_o_count, n_o_count;
    logic                r_o_ldone, n_o_ldone;
    logic                r_o_fdone, n_o_fdone;

    logic                in_acc;
    logic                mem_we;
    logic [PIX_W-1:0]    wr_chroma;
    logic [PIX_W-1:0]    rd_luma, rd_chroma;
    t_cnt                width;
    logic [NL_W-1:0]     lines;
    logic                even;
    logic                div_start;
    logic [SAMPLE_W-1:0] pix_total;
    logic [PROD_W-1:0]   prod;
    logic [NUM_W-1:0]    lo_num, hi_num;
    logic                lo_busy, hi_busy;
    logic [NUM_W-1:0]    lo_q, hi_q;
    logic                last_pix;
    logic                last_line;

    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_valid && o_ready;

    assign width     = eff_width(r_line_width);
    assign lines     = eff_lines(r_num_lines);
    assign even      = ~r_line_cnt[0];
    assign wr_chroma = even ? i_red_diff : i_blue_diff;
    assign last_pix  = ((r_emit_idx + t_cnt'(1)) >= width);
    assign last_line = ((NL_W'(r_line_cnt) + NL_W'(1)) >= lines);

    // ceil(p*N/W) and ceil((p+1)*N/W) as floor((x + W - 1) / W)
    assign pix_total = (r_phase == PH_LUMA) ? r_luma_samples : r_chroma_samples;
    assign prod      = PROD_W'(r_emit_idx) * PROD_W'(pix_total);
    assign lo_num    = NUM_W'(prod) + NUM_W'(width) - NUM_W'(1);
    assign hi_num    = lo_num + NUM_W'(pix_total);

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_line_cnt   = r_line_cnt;
        n_load_idx   = r_load_idx;
        n_emit_idx   = r_emit_idx;
        n_sel_chroma = r_sel_chroma;
        n_tone_off   = r_tone_off;
        n_res_tone   = r_res_tone;
        n_res_count  = r_res_count;
        n_res_ldone  = r_res_ldone;
        n_res_fdone  = r_res_fdone;
        n_o_valid    = r_o_valid;
        n_o_tone     = r_o_tone;
        n_o_count    = r_o_count;
        n_o_ldone    = r_o_ldone;
        n_o_fdone    = r_o_fdone;
        mem_we       = 1'b0;
        div_start    = 1'b0;

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_cmd == CMD_LOAD)) begin
                    if (r_phase == PH_WAIT) begin
                        mem_we = 1'b1;
                        if ((r_load_idx + t_cnt'(1)) >= width) begin
                            n_load_idx = '0;
                            n_emit_idx = '0;
                            n_phase    = PH_SYNC;
                        end else begin
                            n_load_idx = r_load_idx + t_cnt'(1);
                        end
                    end
                end else if (in_acc) begin
                    n_res_ldone = 1'b0;
                    n_res_fdone = 1'b0;
                    case (r_phase)
                        PH_SYNC: begin
                            n_res_tone  = TONE_SYNC;
                            n_res_count = r_sync;
                            n_phase     = PH_SPORCH;
                            n_state     = ST_EMIT;
                        end
                        PH_SPORCH: begin
                            n_res_tone  = TONE_BLACK;
                            n_res_count = r_sync_porch;
                            n_phase     = PH_LUMA;
                            n_emit_idx  = '0;
                            n_state     = ST_EMIT;
                        end
                        PH_LUMA: begin
                            div_start    = 1'b1;
                            n_sel_chroma = 1'b0;
                            n_state      = ST_READ;
                            if (last_pix) begin
                                n_phase    = PH_SEP;
                                n_emit_idx = '0;
                            end else begin
                                n_emit_idx = r_emit_idx + t_cnt'(1);
                            end
                        end
                        PH_SEP: begin
                            n_res_tone  = even ? TONE_BLACK : TONE_SEP_ODD;
                            n_res_count = r_separation;
                            n_phase     = PH_PORCH;
                            n_state     = ST_EMIT;
                        end
                        PH_PORCH: begin
                            n_res_tone  = TONE_PORCH;
                            n_res_count = r_porch;
                            n_phase     = PH_CHROMA;
                            n_emit_idx  = '0;
                            n_state     = ST_EMIT;
                        end
                        PH_CHROMA: begin
                            div_start    = 1'b1;
                            n_sel_chroma = 1'b1;
                            n_state      = ST_READ;
                            if (last_pix) begin
                                n_res_ldone = 1'b1;
                                n_res_fdone = last_line;
                                n_line_cnt  = last_line ? '0 : r_line_cnt + LCNT_W'(1);
                                n_phase     = PH_WAIT;
                                n_emit_idx  = '0;
                                n_load_idx  = '0;
                            end else begin
                                n_emit_idx = r_emit_idx + t_cnt'(1);
                            end
                        end
                        default: begin
                            // request while the line is loading: no segment
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_tone_off = tone_offset(r_sel_chroma ? rd_chroma : rd_luma);
                n_state    = ST_DIV;
            end
            ST_DIV: begin
                if (!lo_busy && !hi_busy) begin
                    n_res_tone  = TONE_BLACK + TONE_W'(r_tone_off);
                    n_res_count = SAMPLE_W'(hi_q - lo_q);
                    n_state     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid = 1'b1;
                    n_o_tone  = r_res_tone;
                    n_o_count = r_res_count;
                    n_o_ldone = r_res_ldone;
                    n_o_fdone = r_res_fdone;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_phase    <= PH_WAIT;
            r_line_cnt <= '0;
            r_load_idx <= '0;
            r_emit_idx <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_line_cnt <= n_line_cnt;
            r_load_idx <= n_load_idx;
            r_emit_idx <= n_emit_idx;
            r_o_valid  <= n_o_valid;
        end
        r_sel_chroma <= n_sel_chroma;
        r_tone_off   <= n_tone_off;
        r_res_tone   <= n_res_tone;
        r_res_count  <= n_res_count;
        r_res_ldone  <= n_res_ldone;
        r_res_fdone  <= n_res_fdone;
        r_o_tone     <= n_o_tone;
        r_o_count    <= n_o_count;
        r_o_ldone    <= n_o_ldone;
        r_o_fdone    <= n_o_fdone;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width     <= LW_W'(320);
            r_num_lines      <= NL_W'(240);
            r_sync           <= SAMPLE_W'(432);
            r_sync_porch     <= SAMPLE_W'(144);
            r_separation     <= SAMPLE_W'(216);
            r_porch          <= SAMPLE_W'(72);
            r_luma_samples   <= SAMPLE_W'(4224);
            r_chroma_samples <= SAMPLE_W'(2112);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LINE_WIDTH: r_line_width     <= i_cfg_data[LW_W-1:0];
                CFG_NUM_LINES:  r_num_lines      <= i_cfg_data[NL_W-1:0];
                CFG_SYNC:       r_sync           <= i_cfg_data;
                CFG_SYNC_PORCH: r_sync_porch     <= i_cfg_data;
                CFG_SEPARATION: r_separation     <= i_cfg_data;
                CFG_PORCH:      r_porch          <= i_cfg_data;
                CFG_LUMA:       r_luma_samples   <= i_cfg_data;
                CFG_CHROMA:     r_chroma_samples <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    sltsu_line_ram u_line_ram (
        .i_clk       (i_clk),
        .i_wr_en     (mem_we),
        .i_wr_addr   (r_load_idx[IDX_W-1:0]),
        .i_wr_luma   (i_luma),
        .i_wr_chroma (wr_chroma),
        .i_rd_addr   (r_emit_idx[IDX_W-1:0]),
        .o_rd_luma   (rd_luma),
        .o_rd_chroma (rd_chroma)
    );

    sltsu_div u_div_lo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (lo_num),
        .i_divisor  (width),
        .o_busy     (lo_busy),
        .o_quotient (lo_q)
    );

    sltsu_div u_div_hi (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (hi_num),
        .i_divisor  (width),
        .o_busy     (hi_busy),
        .o_quotient (hi_q)
    );

    assign o_valid        = r_o_valid;
    assign o_tone_hz      = r_o_tone;
    assign o_sample_count = r_o_count;
    assign o_line_done    = r_o_ldone;
    assign o_frame_done   = r_o_fdone;

endmodule

// ===== tb/sv/tb_sstv_line_tone_scheduler_unit.sv =====
// Self-checking testbench for sstv_line_tone_scheduler_unit: pixel loads and tone
// segment requests against a scan-line schedule predictor. Depends on sltsu_pkg.
`timescale 1ns / 100ps

module tb_sstv_line_tone_scheduler_unit;
    import sltsu_pkg::*;

    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned ITEM_BUDGET  = 1950;
    localparam longint unsigned TONE_STEP_NUM = 31372549;
    localparam longint unsigned TONE_STEP_DEN = 10000000;

    typedef struct packed {
        logic [TONE_W-1:0]   tone;
        logic [SAMPLE_W-1:0] count;
        logic                line_end;
        logic                frame_end;
    } t_tone_seg;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic                 i_cmd;
    logic [PIX_W-1:0]     i_luma;
    logic [PIX_W-1:0]     i_blue_diff;
    logic [PIX_W-1:0]     i_red_diff;
    logic                 o_valid;
    logic                 i_ready;
    logic [TONE_W-1:0]    o_tone_hz;
    logic [SAMPLE_W-1:0]  o_sample_count;
    logic                 o_line_done;
    logic                 o_frame_done;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [SAMPLE_W-1:0]  i_cfg_data;

    // schedule predictor state
    logic [LW_W-1:0]     cfg_width;
    logic [NL_W-1:0]     cfg_lines;
    logic [SAMPLE_W-1:0] cfg_sync, cfg_sync_porch, cfg_sep, cfg_porch;
    logic [SAMPLE_W-1:0] cfg_luma_total, cfg_chroma_total;
    logic [PIX_W-1:0]    luma_line [MAX_LINE_WIDTH];
    logic [PIX_W-1:0]    chroma_line [MAX_LINE_WIDTH];
    t_phase              phase;
    int unsigned         line_index, load_pos, pixel_pos;

    t_tone_seg   segment_queue[$];
    int unsigned items_sent;
    int unsigned lines_done;
    int unsigned mismatch_count;
    int unsigned stuck_cycles;
    int unsigned rx_hold;
    logic        tx_burst;
    logic        rx_burst;

    sstv_line_tone_scheduler_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_luma         (i_luma),
        .i_blue_diff    (i_blue_diff),
        .i_red_diff     (i_red_diff),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_tone_hz      (o_tone_hz),
        .o_sample_count (o_sample_count),
        .o_line_done    (o_line_done),
        .o_frame_done   (o_frame_done),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic void reset_schedule();
        cfg_width        = LW_W'(320);
        cfg_lines        = NL_W'(240);
        cfg_sync         = 16'd432;
        cfg_sync_porch   = 16'd144;
        cfg_sep          = 16'd216;
        cfg_porch        = 16'd72;
        cfg_luma_total   = 16'd4224;
        cfg_chroma_total = 16'd2112;
        phase            = PH_WAIT;
        line_index       = 0;
        load_pos         = 0;
        pixel_pos        = 0;
    endfunction

    function automatic int unsigned active_width();
        if (cfg_width == '0) begin
            return 1;
        end
        if (cfg_width > MAX_LINE_WIDTH) begin
            return MAX_LINE_WIDTH;
        end
        return 32'(cfg_width);
    endfunction

    function automatic int unsigned active_lines();
        if (cfg_lines == '0) begin
            return 1;
        end
        if (cfg_lines > MAX_LINES) begin
            return MAX_LINES;
        end
        return 32'(cfg_lines);
    endfunction

    function automatic logic [TONE_W-1:0] pixel_tone(input logic [PIX_W-1:0] v);
        longint unsigned scaled;
        scaled = 64'(v);
        scaled = (scaled * TONE_STEP_NUM) / TONE_STEP_DEN;
        return TONE_BLACK + TONE_W'(scaled);
    endfunction

    // samples between the ceiling boundaries of pixel p and p + 1
    function automatic logic [SAMPLE_W-1:0] pixel_samples(input int unsigned p,
                                                          input logic [SAMPLE_W-1:0] total,
                                                          input int unsigned w);
        longint unsigned n, d, lo, hi;
        n  = 64'(total);
        d  = 64'(w);
        lo = (p * n + d - 1) / d;
        hi = ((p + 1) * n + d - 1) / d;
        return SAMPLE_W'(hi - lo);
    endfunction

    function automatic void step_line_schedule(input logic cmd, input logic [PIX_W-1:0] y,
                                               input logic [PIX_W-1:0] cb,
                                               input logic [PIX_W-1:0] cr);
        int unsigned w;
        logic        even_row;
        logic        emits;
        t_tone_seg   seg;
        w        = active_width();
        even_row = (line_index % 2) == 0;
        emits    = 1'b1;
        seg      = '0;
        if (cmd == CMD_LOAD) begin
            if (phase == PH_WAIT) begin
                luma_line[IDX_W'(load_pos)]   = y;
                chroma_line[IDX_W'(load_pos)] = even_row ? cr : cb;
                if (load_pos + 1 >= w) begin
                    load_pos  = 0;
                    pixel_pos = 0;
                    phase     = PH_SYNC;
                end else begin
                    load_pos++;
                end
            end
            return;
        end
        case (phase)
            PH_SYNC: begin
                seg.tone  = TONE_SYNC;
                seg.count = cfg_sync;
                phase     = PH_SPORCH;
            end
            PH_SPORCH: begin
                seg.tone  = TONE_BLACK;
                seg.count = cfg_sync_porch;
                phase     = PH_LUMA;
                pixel_pos = 0;
            end
            PH_LUMA: begin
                seg.tone  = pixel_tone(luma_line[IDX_W'(pixel_pos)]);
                seg.count = pixel_samples(pixel_pos, cfg_luma_total, w);
                if (pixel_pos + 1 >= w) begin
                    phase     = PH_SEP;
                    pixel_pos = 0;
                end else begin
                    pixel_pos++;
                end
            end
            PH_SEP: begin
                seg.tone  = even_row ? TONE_BLACK : TONE_SEP_ODD;
                seg.count = cfg_sep;
                phase     = PH_PORCH;
            end
            PH_PORCH: begin
                seg.tone  = TONE_PORCH;
                seg.count = cfg_porch;
                phase     = PH_CHROMA;
                pixel_pos = 0;
            end
            PH_CHROMA: begin
                seg.tone  = pixel_tone(chroma_line[IDX_W'(pixel_pos)]);
                seg.count = pixel_samples(pixel_pos, cfg_chroma_total, w);
                if (pixel_pos + 1 >= w) begin
                    seg.line_end = 1'b1;
                    if (line_index + 1 >= active_lines()) begin
                        seg.frame_end = 1'b1;
                        line_index    = 0;
                    end else begin
                        line_index++;
                    end
                    phase     = PH_WAIT;
                    pixel_pos = 0;
                    load_pos  = 0;
                    lines_done++;
                end else begin
                    pixel_pos++;
                end
            end
            default: emits = 1'b0;
        endcase
        if (emits) begin
            segment_queue.push_back(seg);
        end
    endfunction

    // returns just after the posedge that accepted the transaction
    task automatic send_item(input logic cmd, input logic [PIX_W-1:0] y,
                             input logic [PIX_W-1:0] cb, input logic [PIX_W-1:0] cr);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, 14);
        @(negedge i_clk);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_cmd       <= cmd;
        i_luma      <= y;
        i_blue_diff <= cb;
        i_red_diff  <= cr;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        step_line_schedule(cmd, y, cb, cr);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] reg_index,
                                  input logic [SAMPLE_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= reg_index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (reg_index)
            CFG_LINE_WIDTH: cfg_width        = value[LW_W-1:0];
            CFG_NUM_LINES:  cfg_lines        = value[NL_W-1:0];
            CFG_SYNC:       cfg_sync         = value;
            CFG_SYNC_PORCH: cfg_sync_porch   = value;
            CFG_SEPARATION: cfg_sep          = value;
            CFG_PORCH:      cfg_porch        = value;
            CFG_LUMA:       cfg_luma_total   = value;
            CFG_CHROMA:     cfg_chroma_total = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // stop sending, collect every outstanding segment, let loads finish
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (segment_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // drives the current line forward; noise items are the command the block ignores
    task automatic run_line(input int unsigned noise_pct, input int unsigned cut_after);
        int unsigned start_lines;
        int unsigned sent;
        logic        wanted;
        start_lines = lines_done;
        sent        = 0;
        do begin
            wanted = (phase == PH_WAIT) ? CMD_LOAD : CMD_REQUEST;
            if ($urandom_range(99) < noise_pct) begin
                wanted = ~wanted;
            end
            send_item(wanted, PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
            sent++;
        end while (lines_done == start_lines && (cut_after == 0 || sent < cut_after));
    endtask

    task automatic finish_line();
        if (phase != PH_WAIT || load_pos != 0) begin
            run_line(0, 0);
        end
    endtask

    function automatic logic [SAMPLE_W-1:0] random_length();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic random_setup();
        int unsigned pick;
        int          r;
        pick = $urandom_range(19);
        if (pick < 14) begin
            write_register(CFG_LINE_WIDTH, SAMPLE_W'($urandom_range(1, 12)));
        end else if (pick < 19) begin
            write_register(CFG_LINE_WIDTH, SAMPLE_W'($urandom_range(13, 64)));
        end else begin
            write_register(CFG_LINE_WIDTH, SAMPLE_W'($urandom_range(65, 160)));
        end
        pick = $urandom_range(19);
        if (pick < 16) begin
            write_register(CFG_NUM_LINES, SAMPLE_W'($urandom_range(1, 5)));
        end else if (pick < 18) begin
            write_register(CFG_NUM_LINES, '0);
        end else begin
            write_register(CFG_NUM_LINES, SAMPLE_W'($urandom));
        end
        for (r = CFG_SYNC; r <= CFG_CHROMA; r++) begin
            write_register(CFG_IDX_W'(r), random_length());
        end
    endtask

    // reset register values: full 320-pixel load, first segments, then a short finish
    task automatic test_defaults();
        send_item(CMD_REQUEST, '0, '0, '0);   // nothing loaded: no segment
        run_line(3, 360);
        settle();
        write_register(CFG_LINE_WIDTH, 16'd24);
        finish_line();
    endtask

    task automatic test_pixel_extremes();
        int n;
        settle();
        write_register(CFG_LINE_WIDTH, 16'd3);
        for (n = 0; n < 2; n++) begin
            send_item(CMD_LOAD, 8'h00, 8'hFF, 8'h00);
            send_item(CMD_REQUEST, 8'hFF, 8'hFF, 8'hFF);   // still loading
            send_item(CMD_LOAD, 8'hFF, 8'h00, 8'hFF);
            send_item(CMD_LOAD, 8'h80, 8'h7F, 8'h01);
            send_item(CMD_LOAD, 8'h55, 8'hAA, 8'h33);       // emitting: ignored
            run_line(0, 0);
        end
    endtask

    task automatic test_register_extremes();
        int r;
        settle();
        write_register(CFG_LINE_WIDTH, 16'hFC00);   // field reads 0, used as one pixel
        write_register(CFG_NUM_LINES, 16'h0000);
        for (r = CFG_SYNC; r <= CFG_CHROMA; r++) begin
            write_register(CFG_IDX_W'(r), '0);
        end
        repeat (2) run_line(0, 0);
        settle();
        write_register(CFG_LINE_WIDTH, 16'h03FF);   // clamps to the full store
        write_register(CFG_NUM_LINES, 16'hFFFF);
        for (r = CFG_SYNC; r <= CFG_CHROMA; r++) begin
            write_register(CFG_IDX_W'(r), '1);
        end
        run_line(4, 600);
        settle();
        write_register(CFG_LINE_WIDTH, 16'd5);   // emission already past the last pixel
        finish_line();
        settle();
        write_register(CFG_LINE_WIDTH, 16'd1);
        write_register(CFG_NUM_LINES, 16'd1024);
        run_line(0, 0);
    endtask

    task automatic test_frame_wrap();
        settle();
        write_register(CFG_LINE_WIDTH, 16'd2);
        write_register(CFG_NUM_LINES, 16'd3);
        write_register(CFG_LUMA, 16'd5);
        write_register(CFG_CHROMA, 16'd3);
        repeat (4) run_line(0, 0);
        while (line_index != 2) run_line(0, 0);
        settle();
        write_register(CFG_NUM_LINES, 16'd2);   // counter already past the new last line
        run_line(0, 0);
    endtask

    task automatic test_midline_changes();
        settle();
        write_register(CFG_LINE_WIDTH, 16'd6);
        write_register(CFG_NUM_LINES, 16'd4);
        write_register(CFG_LUMA, 16'd100);
        write_register(CFG_CHROMA, 16'd50);
        repeat (4) send_item(CMD_LOAD, PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
        settle();
        write_register(CFG_LINE_WIDTH, 16'd3);   // next load already passes the last pixel
        send_item(CMD_LOAD, PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
        repeat (3) send_item(CMD_REQUEST, '0, '0, '0);
        settle();
        write_register(CFG_LUMA, 16'd999);
        write_register(CFG_CHROMA, 16'd7);
        write_register(CFG_LINE_WIDTH, 16'd2);
        repeat (3) send_item(CMD_REQUEST, '0, '0, '0);
        settle();
        write_register(CFG_NUM_LINES, 16'd1);
        write_register(CFG_SEPARATION, 16'd11);
        finish_line();
    endtask

    task automatic test_output_backpressure();
        settle();
        write_register(CFG_LINE_WIDTH, 16'd8);
        run_line(0, 8);
        rx_hold  = HOLD_CYCLES;
        tx_burst = 1'b1;
        repeat (12) send_item(CMD_REQUEST, '0, '0, '0);
        tx_burst = 1'b0;
        settle();
        finish_line();
    endtask

    task automatic test_random_traffic();
        int unsigned left;
        settle();
        random_setup();
        while (items_sent < ITEM_BUDGET) begin
            tx_burst = ($urandom_range(3) == 0);
            rx_burst = ($urandom_range(3) == 0);
            if (phase == PH_WAIT && load_pos == 0 && $urandom_range(3) == 0) begin
                settle();
                random_setup();
            end
            left = ITEM_BUDGET - items_sent;
            if ($urandom_range(19) == 0) begin
                run_line(10, $urandom_range(1, 8));   // broken-off line, resumed later
            end else begin
                run_line($urandom_range(0, 10), left);
            end
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    // receiver: per-transaction stall draw plus an optional long hold-off
    initial begin : rx_side
        int unsigned wait_left;
        i_ready   = 1'b0;
        wait_left = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold != 0) begin
                i_ready <= 1'b0;
                rx_hold--;
            end else if (wait_left != 0) begin
                i_ready <= 1'b0;
                wait_left--;
            end else begin
                i_ready <= 1'b1;
            end
            @(posedge i_clk);
            if (i_ready && o_valid) begin
                wait_left = rx_burst ? 0 : $urandom_range(0, 14);
            end
        end
    end

    always @(posedge i_clk) begin : segment_check
        t_tone_seg want;
        if (i_rst_n && o_valid && i_ready) begin
            if (segment_queue.size() == 0) begin
                $display("%0t: segment expected none, actual tone %0d count %0d line %0b frame %0b",
                         $time, o_tone_hz, o_sample_count, o_line_done, o_frame_done);
                mismatch_count++;
            end else begin
                want = segment_queue.pop_front();
                if (o_tone_hz !== want.tone) begin
                    $display("%0t: tone_hz expected %0d actual %0d", $time, want.tone, o_tone_hz);
                    mismatch_count++;
                end
                if (o_sample_count !== want.count) begin
                    $display("%0t: sample_count expected %0d actual %0d",
                             $time, want.count, o_sample_count);
                    mismatch_count++;
                end
                if (o_line_done !== want.line_end) begin
                    $display("%0t: line_done expected %0b actual %0b",
                             $time, want.line_end, o_line_done);
                    mismatch_count++;
                end
                if (o_frame_done !== want.frame_end) begin
                    $display("%0t: frame_done expected %0b actual %0b",
                             $time, want.frame_end, o_frame_done);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_cmd          = CMD_LOAD;
        i_luma         = '0;
        i_blue_diff    = '0;
        i_red_diff     = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_LINE_WIDTH;
        i_cfg_data     = '0;
        items_sent     = 0;
        lines_done     = 0;
        mismatch_count = 0;
        stuck_cycles   = 0;
        rx_hold        = 0;
        tx_burst       = 1'b0;
        rx_burst       = 1'b0;
        reset_schedule();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_defaults();
        test_pixel_extremes();
        test_register_extremes();
        test_frame_wrap();
        test_midline_changes();
        test_output_backpressure();
        test_random_traffic();

        settle();
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
